// ----- src/urb_pkg.sv -----
// Shared types and constants for the UART receive/transmit ring buffer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package urb_pkg;

    // Request opcode in the low bits of the input request.
    typedef enum logic [1:0] {
        CMD_EVENT = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_GET   = 2'd2
    } t_cmd;

    // Interrupt identification codes that matter here.
    localparam logic [2:0] ID_TX_EMPTY = 3'h1;
    localparam logic [2:0] ID_DATA     = 3'h2;
    localparam logic [2:0] ID_TIMEOUT  = 3'h6;

    // A put needs more than this many free slots.
    localparam int PUT_MARGIN = 3;

    localparam int IN_W  = 24;
    localparam int OUT_W = 32;
    localparam int LVL_W = 6;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
    } t_ring_stat;

endpackage

`default_nettype wire

// ----- src/urb_ring.sv -----
// One ring: byte memory, read/write pointers, fill count, prefetched head.
// Depends on urb_pkg.
`default_nettype none

module urb_ring
    import urb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ring_ctl                i_ctl,
    input  wire logic [7:0]               i_wdata,
    output t_ring_stat                    o_stat,
    output logic [7:0]                    o_head,
    output logic [$clog2(DEPTH)-1:0]      o_level,
    output logic [$clog2(DEPTH)-1:0]      o_level_next
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_level, n_level;
    logic [7:0]    r_head;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (i_ctl.push) begin
            n_wptr  = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            n_level = r_level + 1'b1;
        end
        if (i_ctl.pop) begin
            n_rptr  = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Head prefetch at the next read pointer; forward a write to that slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (r_wptr == n_rptr)) begin
            r_head <= i_wdata;
        end else begin
            r_head <= r_mem[n_rptr];
        end
    end

    assign o_stat.empty  = (r_level == '0);
    assign o_head        = r_head;
    assign o_level       = r_level;
    assign o_level_next  = n_level;

endmodule

`default_nettype wire

// ----- src/uart_rx_tx_ring_buffer.sv -----
// Top level: UART channel buffer with receive and transmit rings.
// Depends on urb_pkg and urb_ring.
//
//  channel  | dir | tdata bits | contents
//  ---------+-----+------------+-----------------------------------------
//  s_axis   | in  | 24         | requests: event, put or get
//  m_axis   | out | 32         | one result per request
//
// Each request is decoded and applied in the cycle it is accepted; its
// result lands in the output register at that edge. One request per cycle
// is sustained; s_axis_tready drops only during reset and while a result
// waits with m_axis_tready low. Reset (synchronous, active low) empties both
// rings, marks the transmitter idle and clears the result valid flag. Ring
// memory contents are not cleared.
`default_nettype none

module uart_rx_tx_ring_buffer
    import urb_pkg::*;
#(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] cmd, [4:2] int_id, [12:5] rx_byte, [20:13] put_byte, [23:21] zero
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] put_accepted, [10] get_valid,
    // [18:11] get_byte, [19] rx_dropped, [25:20] rx_level, [31:26] tx_level
    output logic [OUT_W-1:0]      m_axis_tdata
);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_EW = (RX_AW > LVL_W) ? RX_AW : LVL_W;
    localparam int TX_EW = (TX_AW > LVL_W) ? TX_AW : LVL_W;
    localparam logic [RX_AW-1:0] RX_FULL = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_PUT_LIMIT = TX_AW'(TX_DEPTH - 1 - PUT_MARGIN);

    // Request fields
    t_cmd       w_cmd;
    logic [2:0] w_id;
    logic [7:0] w_rx_byte;
    logic [7:0] w_put_byte;
    logic       w_acc;

    // Ring interface
    t_ring_ctl        w_rx_ctl, w_tx_ctl;
    t_ring_stat       w_rx_stat, w_tx_stat;
    logic [7:0]       w_rx_head, w_tx_head;
    logic [RX_AW-1:0] w_rx_lvl, w_rx_lvl_next;
    logic [TX_AW-1:0] w_tx_lvl, w_tx_lvl_next;
    logic [RX_EW-1:0] w_rx_lvl_ext;
    logic [TX_EW-1:0] w_tx_lvl_ext;

    // Result fields
    logic       n_tx_valid, n_put_ok, n_get_valid, n_dropped;
    logic [7:0] n_tx_byte, n_get_byte;

    logic             r_idle, n_idle;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    assign w_cmd      = t_cmd'(s_axis_tdata[1:0]);
    assign w_id       = s_axis_tdata[4:2];
    assign w_rx_byte  = s_axis_tdata[12:5];
    assign w_put_byte = s_axis_tdata[20:13];

    // Output register frees up when its result is taken this cycle.
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_rx_ctl    = '0;
        w_tx_ctl    = '0;
        n_tx_valid  = 1'b0;
        n_tx_byte   = 8'h00;
        n_put_ok    = 1'b0;
        n_get_valid = 1'b0;
        n_get_byte  = 8'h00;
        n_dropped   = 1'b0;
        n_idle      = r_idle;
        if (w_acc) begin
            case (w_cmd)
                CMD_EVENT: begin
                    if ((w_id == ID_DATA) || (w_id == ID_TIMEOUT)) begin
                        // one slot stays empty: drop when full
                        if (w_rx_lvl == RX_FULL) begin
                            n_dropped = 1'b1;
                        end else begin
                            w_rx_ctl.push = 1'b1;
                        end
                    end else if (w_id == ID_TX_EMPTY) begin
                        if (w_tx_stat.empty) begin
                            n_idle = 1'b1;
                        end else begin
                            w_tx_ctl.pop = 1'b1;
                            n_tx_valid   = 1'b1;
                            n_tx_byte    = w_tx_head;
                            n_idle       = 1'b0;
                        end
                    end
                end
                CMD_PUT: begin
                    // refused unless more than PUT_MARGIN slots are free
                    if (w_tx_lvl < TX_PUT_LIMIT) begin
                        n_put_ok = 1'b1;
                        if (r_idle) begin
                            n_idle     = 1'b0;
                            n_tx_valid = 1'b1;
                            n_tx_byte  = w_put_byte;
                        end else begin
                            w_tx_ctl.push = 1'b1;
                        end
                    end
                end
                CMD_GET: begin
                    if (!w_rx_stat.empty) begin
                        w_rx_ctl.pop = 1'b1;
                        n_get_valid  = 1'b1;
                        n_get_byte   = w_rx_head;
                    end
                end
                default: begin
                    // unused opcode: no effect
                end
            endcase
        end
    end

    urb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_rx_ctl),
        .i_wdata      (w_rx_byte),
        .o_stat       (w_rx_stat),
        .o_head       (w_rx_head),
        .o_level      (w_rx_lvl),
        .o_level_next (w_rx_lvl_next)
    );

    urb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_tx_ctl),
        .i_wdata      (w_put_byte),
        .o_stat       (w_tx_stat),
        .o_head       (w_tx_head),
        .o_level      (w_tx_lvl),
        .o_level_next (w_tx_lvl_next)
    );

    // Levels reported modulo 64
    assign w_rx_lvl_ext = RX_EW'(w_rx_lvl_next);
    assign w_tx_lvl_ext = TX_EW'(w_tx_lvl_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_idle <= n_idle;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_data <= {w_tx_lvl_ext[LVL_W-1:0], w_rx_lvl_ext[LVL_W-1:0], n_dropped,
                           n_get_byte, n_get_valid, n_put_ok, n_tx_byte, n_tx_valid};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- src/urb_checker.sv -----
// Port-level checks on the ring buffer's result stream, bound to the top.
// Depends on urb_pkg and uart_rx_tx_ring_buffer.
`default_nettype none

module urb_checker
    import urb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    // no result is shown right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // put, get and drop come from distinct requests
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0({m_axis_tdata[9], m_axis_tdata[10], m_axis_tdata[19]}))
        else $error("put, get and drop flagged together");

    // bytes read as zero when their valid flag is low
    a_zero_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] || (m_axis_tdata[8:1] == 8'h00))
                       && (m_axis_tdata[10] || (m_axis_tdata[18:11] == 8'h00)))
        else $error("byte nonzero without its valid flag");

endmodule

bind uart_rx_tx_ring_buffer urb_checker u_urb_checker (.*);

`default_nettype wire
